@@ sv/i2cwr_pkg.sv @@
// Shared constants and helper functions for the I2C write-then-read sequencer.
`timescale 1ns / 1ps
`default_nettype none
package i2cwr_pkg;

	// Limits of the transaction.
	localparam int MAX_WRITE = 4;
	localparam int READ_MAX  = 32;

	// Bus command codes issued on each step.
	localparam logic [2:0] CMD_NONE   = 3'd0;
	localparam logic [2:0] CMD_START  = 3'd1;
	localparam logic [2:0] CMD_TX     = 3'd2;
	localparam logic [2:0] CMD_RSTART = 3'd3;
	localparam logic [2:0] CMD_RCEN   = 3'd4;
	localparam logic [2:0] CMD_ACK    = 3'd5;
	localparam logic [2:0] CMD_NACK   = 3'd6;
	localparam logic [2:0] CMD_STOP   = 3'd7;

	// Configuration register indexes.
	localparam logic [2:0] REG_WRITE_ADDRESS    = 3'd0;
	localparam logic [2:0] REG_READ_ADDRESS     = 3'd1;
	localparam logic [2:0] REG_WRITE_LENGTH     = 3'd2;
	localparam logic [2:0] REG_WRITE_BYTE_ZERO  = 3'd3;
	localparam logic [2:0] REG_WRITE_BYTE_ONE   = 3'd4;
	localparam logic [2:0] REG_WRITE_BYTE_TWO   = 3'd5;
	localparam logic [2:0] REG_WRITE_BYTE_THREE = 3'd6;
	localparam logic [2:0] REG_READ_CAPACITY    = 3'd7;

	// Read capacity with zero taken as one and large values clipped.
	function automatic logic [5:0] eff_capacity(input logic [5:0] cap);
		logic [5:0] c;
		c = cap;
		if (c == 6'd0) begin
			c = 6'd1;
		end
		if (c > 6'(READ_MAX)) begin
			c = 6'(READ_MAX);
		end
		return c;
	endfunction

	// Write length with zero taken as one and large values clipped.
	function automatic logic [2:0] eff_write_length(input logic [2:0] len);
		logic [2:0] w;
		w = len;
		if (w == 3'd0) begin
			w = 3'd1;
		end
		if (w > 3'(MAX_WRITE)) begin
			w = 3'(MAX_WRITE);
		end
		return w;
	endfunction

endpackage
`default_nettype wire

@@ sv/i2c_write_read_length_prefixed.sv @@
// Top level of the I2C write-then-read sequencer with a length-prefixed read.
// An input item is held in the input register and its result in the output register.
// One item per cycle while the output is not stalled; the sequencer takes one step per item.
// The input register frees itself whenever the output register is empty or being drained.
// Reset (arst_n low, asynchronous) empties both stages, sets the sequencer to idle and
// returns every configuration register to its documented default.
`timescale 1ns / 1ps
`default_nettype none
module i2c_write_read_length_prefixed (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Configuration write port.
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	// Input channel: one bus-completion event per item.
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       nack_seen,
	input  wire logic [7:0] rx_byte,
	// Output channel: one command item per event.
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      bus_command,
	output logic [7:0]      tx_byte,
	output logic            rx_store,
	output logic [4:0]      rx_index,
	output logic [7:0]      rx_data,
	output logic [5:0]      read_length,
	output logic            error_no_ack,
	output logic            done_res
);
	import i2cwr_pkg::*;

	// Sequencer phases. Codes not listed here behave as idle.
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_WADDR  = 4'd2,
		PH_WDATA  = 4'd3,
		PH_RSTART = 4'd4,
		PH_RADDR  = 4'd5,
		PH_RCEN   = 4'd6,
		PH_RECV   = 4'd7,
		PH_STOP   = 4'd8,
		PH_DONE   = 4'd9
	} phase_t;

	// Configuration registers.
	logic [7:0] write_address_q;
	logic [7:0] read_address_q;
	logic [2:0] write_length_q;
	logic [7:0] write_bytes_q [MAX_WRITE];
	logic [5:0] read_capacity_q;

	// Sequencer state.
	phase_t     phase_q;
	logic [5:0] byte_count_q;
	logic [5:0] clamped_q;
	logic       error_q;

	// Input stage.
	logic       valid_s1;
	logic       nack_s1;
	logic [7:0] rx_s1;

	// Output stage.
	logic       valid_s2;
	logic [2:0] cmd_s2;
	logic [7:0] tx_s2;
	logic       store_s2;
	logic [4:0] idx_s2;
	logic [7:0] data_s2;
	logic [5:0] len_s2;
	logic       err_s2;
	logic       done_s2;

	// The item in the input stage moves on when the output stage is free or being taken.
	logic advance;
	logic in_accept;

	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// Next-state and result logic for one step.
	phase_t     phase_n;
	logic [5:0] count_n;
	logic [5:0] clamp_n;
	logic       err_n;
	logic [2:0] cmd_n;
	logic [7:0] tx_n;
	logic       store_n;
	logic [4:0] idx_n;
	logic [7:0] data_n;
	logic       done_n;
	logic [8:0] prefix_len;

	assign prefix_len = {1'b0, rx_s1} + 9'd1;

	always_comb begin
		phase_n = phase_q;
		count_n = byte_count_q;
		clamp_n = clamped_q;
		err_n   = error_q;
		cmd_n   = CMD_NONE;
		tx_n    = 8'd0;
		store_n = 1'b0;
		idx_n   = 5'd0;
		data_n  = 8'd0;
		done_n  = 1'b0;
		case (phase_q)
			PH_WADDR: begin
				cmd_n   = CMD_TX;
				tx_n    = write_address_q;
				phase_n = PH_WDATA;
			end
			PH_WDATA: begin
				if (nack_s1) begin
					err_n   = 1'b1;
					cmd_n   = CMD_STOP;
					phase_n = PH_DONE;
				end else begin
					cmd_n = CMD_TX;
					if (byte_count_q < 6'(MAX_WRITE)) begin
						tx_n = write_bytes_q[byte_count_q[1:0]];
					end
					count_n = byte_count_q + 6'd1;
					if (count_n >= {3'd0, eff_write_length(write_length_q)}) begin
						phase_n = PH_RSTART;
					end
				end
			end
			PH_RSTART: begin
				if (nack_s1) begin
					err_n   = 1'b1;
					cmd_n   = CMD_STOP;
					phase_n = PH_DONE;
				end else begin
					cmd_n   = CMD_RSTART;
					phase_n = PH_RADDR;
				end
			end
			PH_RADDR: begin
				cmd_n   = CMD_TX;
				tx_n    = read_address_q;
				count_n = 6'd0;
				phase_n = PH_RCEN;
			end
			PH_RCEN: begin
				if (nack_s1) begin
					err_n   = 1'b1;
					cmd_n   = CMD_STOP;
					phase_n = PH_DONE;
				end else begin
					cmd_n   = CMD_RCEN;
					phase_n = PH_RECV;
				end
			end
			PH_RECV: begin
				store_n = 1'b1;
				idx_n   = byte_count_q[4:0];
				data_n  = rx_s1;
				count_n = byte_count_q + 6'd1;
				// The first byte read is the length prefix; it can only shorten the read.
				if ((count_n == 6'd1) && (prefix_len < {3'd0, clamped_q})) begin
					clamp_n = prefix_len[5:0];
				end
				if (count_n >= clamp_n) begin
					cmd_n   = CMD_NACK;
					phase_n = PH_STOP;
				end else begin
					cmd_n   = CMD_ACK;
					phase_n = PH_RCEN;
				end
			end
			PH_STOP: begin
				cmd_n   = CMD_STOP;
				phase_n = PH_DONE;
			end
			PH_DONE: begin
				done_n  = 1'b1;
				phase_n = PH_IDLE;
			end
			default: begin
				// Idle, or any unused code: open a new transaction with a start.
				count_n = 6'd0;
				err_n   = 1'b0;
				clamp_n = eff_capacity(read_capacity_q);
				cmd_n   = CMD_START;
				phase_n = PH_WADDR;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_address_q  <= 8'd0;
			read_address_q   <= 8'd1;
			write_length_q   <= 3'd1;
			write_bytes_q[0] <= 8'd0;
			write_bytes_q[1] <= 8'd0;
			write_bytes_q[2] <= 8'd0;
			write_bytes_q[3] <= 8'd0;
			read_capacity_q  <= 6'(READ_MAX);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WRITE_ADDRESS:    write_address_q  <= cfg_data;
				REG_READ_ADDRESS:     read_address_q   <= cfg_data;
				REG_WRITE_LENGTH:     write_length_q   <= cfg_data[2:0];
				REG_WRITE_BYTE_ZERO:  write_bytes_q[0] <= cfg_data;
				REG_WRITE_BYTE_ONE:   write_bytes_q[1] <= cfg_data;
				REG_WRITE_BYTE_TWO:   write_bytes_q[2] <= cfg_data;
				REG_WRITE_BYTE_THREE: write_bytes_q[3] <= cfg_data;
				REG_READ_CAPACITY:    read_capacity_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Sequencer state advances once per item leaving the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			byte_count_q <= 6'd0;
			clamped_q    <= 6'(READ_MAX);
			error_q      <= 1'b0;
		end else if (advance) begin
			phase_q      <= phase_n;
			byte_count_q <= count_n;
			clamped_q    <= clamp_n;
			error_q      <= err_n;
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			nack_s1 <= nack_seen;
			rx_s1   <= rx_byte;
		end
	end

	// Output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s2   <= cmd_n;
			tx_s2    <= tx_n;
			store_s2 <= store_n;
			idx_s2   <= idx_n;
			data_s2  <= data_n;
			len_s2   <= clamp_n;
			err_s2   <= err_n;
			done_s2  <= done_n;
		end
	end

	assign out_valid    = valid_s2;
	assign bus_command  = cmd_s2;
	assign tx_byte      = tx_s2;
	assign rx_store     = store_s2;
	assign rx_index     = idx_s2;
	assign rx_data      = data_s2;
	assign read_length  = len_s2;
	assign error_no_ack = err_s2;
	assign done_res     = done_s2;

`ifndef ASSERT_OFF
	// A finished step moves into the output stage.
	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced item did not reach the output stage");

	// A held input item is not dropped.
	a_held_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("held input item was lost");

	// The completion step carries no bus command.
	a_done_no_command: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && done_s2) |-> (cmd_s2 == CMD_NONE))
		else $error("completion step issued a bus command");

	// A stored read byte always comes with an ack or a nack.
	a_store_with_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && store_s2) |-> ((cmd_s2 == CMD_ACK) || (cmd_s2 == CMD_NACK)))
		else $error("read byte stored without ack or nack");

	// The clamped read length stays within one and the capacity limit.
	a_length_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(clamped_q >= 6'd1) && (clamped_q <= 6'(READ_MAX)))
		else $error("clamped read length out of range");
`endif

endmodule
`default_nettype wire

@@ sim/i2c_write_read_length_prefixed_tb.sv @@
// Self-checking testbench for the I2C write-then-read sequencer with a length-prefixed read.
`timescale 1ns / 1ps
module i2c_write_read_length_prefixed_tb;
	import i2cwr_pkg::*;

	// One command item as the block presents it on its output channel.
	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] tx;
		logic       store;
		logic [4:0] idx;
		logic [7:0] data;
		logic [5:0] rlen;
		logic       err;
		logic       done;
	} cmd_item_t;

	// One row of the directed script. Where typed is set, the expected item is the
	// one written in the row; otherwise the sequencer model supplies it.
	typedef struct {
		logic      nack;
		logic [7:0] rx;
		bit        typed;
		cmd_item_t want;
	} script_row_t;

	// Steps of the transaction as the model tracks them.
	typedef enum logic [3:0] {
		PH_IDLE, PH_ADDR_W, PH_WRITE, PH_RSTART, PH_ADDR_R,
		PH_RCEN, PH_RECV, PH_NACK, PH_DONE
	} seq_phase_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_WRITE_ADDRESS;
	logic [7:0] cfg_data = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       nack_seen = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] bus_command;
	logic [7:0] tx_byte;
	logic       rx_store;
	logic [4:0] rx_index;
	logic [7:0] rx_data;
	logic [5:0] read_length;
	logic       error_no_ack;
	logic       done_res;

	i2c_write_read_length_prefixed dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.nack_seen(nack_seen),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bus_command(bus_command),
		.tx_byte(tx_byte),
		.rx_store(rx_store),
		.rx_index(rx_index),
		.rx_data(rx_data),
		.read_length(read_length),
		.error_no_ack(error_no_ack),
		.done_res(done_res)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model copy of the configuration registers.
	logic [7:0] wr_addr_reg;
	logic [7:0] rd_addr_reg;
	logic [2:0] write_len_reg;
	logic [7:0] wr_bytes [0:3];
	logic [5:0] read_cap_reg;

	// Model copy of the sequencer state.
	seq_phase_t seq_phase;
	logic [5:0] seq_count;
	logic [5:0] seq_clamp;
	logic       seq_err;

	// Command items the block still owes, oldest first.
	cmd_item_t   pending_commands [$];
	script_row_t script [$];
	cmd_item_t   oldest;
	int          mismatches = 0;
	int          result_count = 0;

	// When set, the matching side runs without gaps for the current phase.
	bit in_calm = 1'b0;
	bit stall_calm = 1'b0;

	function automatic cmd_item_t predict_command(input logic nack, input logic [7:0] rx);
		cmd_item_t  r;
		logic [5:0] cap;
		logic [2:0] wlen;
		r = '0;
		r.cmd = CMD_NONE;
		// Capacity and write length are clipped into their legal ranges on every use.
		cap = (read_cap_reg == 6'd0) ? 6'd1 :
			(read_cap_reg > 6'(READ_MAX)) ? 6'(READ_MAX) : read_cap_reg;
		wlen = (write_len_reg == 3'd0) ? 3'd1 :
			(write_len_reg > 3'(MAX_WRITE)) ? 3'(MAX_WRITE) : write_len_reg;
		// A missing acknowledge only counts in the steps that follow a transmitted byte or a sent acknowledge.
		if (nack && (seq_phase == PH_WRITE || seq_phase == PH_RSTART || seq_phase == PH_RCEN)) begin
			seq_err = 1'b1;
			r.cmd = CMD_STOP;
			seq_phase = PH_DONE;
		end else begin
			case (seq_phase)
				PH_IDLE: begin
					seq_count = 6'd0;
					seq_err = 1'b0;
					seq_clamp = cap;
					r.cmd = CMD_START;
					seq_phase = PH_ADDR_W;
				end
				PH_ADDR_W: begin
					r.cmd = CMD_TX;
					r.tx = wr_addr_reg;
					seq_phase = PH_WRITE;
				end
				PH_WRITE: begin
					r.cmd = CMD_TX;
					r.tx = (seq_count < 6'd4) ? wr_bytes[seq_count[1:0]] : 8'h00;
					seq_count = seq_count + 6'd1;
					seq_phase = (seq_count >= {3'b000, wlen}) ? PH_RSTART : PH_WRITE;
				end
				PH_RSTART: begin
					r.cmd = CMD_RSTART;
					seq_phase = PH_ADDR_R;
				end
				PH_ADDR_R: begin
					r.cmd = CMD_TX;
					r.tx = rd_addr_reg;
					seq_count = 6'd0;
					seq_phase = PH_RCEN;
				end
				PH_RCEN: begin
					r.cmd = CMD_RCEN;
					seq_phase = PH_RECV;
				end
				PH_RECV: begin
					r.store = 1'b1;
					r.idx = seq_count[4:0];
					r.data = rx;
					seq_count = seq_count + 6'd1;
					// The first byte read is the length prefix; it can only shorten the read.
					if (seq_count == 6'd1 && ({1'b0, rx} + 9'd1) < {3'b000, seq_clamp}) begin
						seq_clamp = rx[5:0] + 6'd1;
					end
					if (seq_count >= seq_clamp) begin
						r.cmd = CMD_NACK;
						seq_phase = PH_NACK;
					end else begin
						r.cmd = CMD_ACK;
						seq_phase = PH_RCEN;
					end
				end
				PH_NACK: begin
					r.cmd = CMD_STOP;
					seq_phase = PH_DONE;
				end
				default: begin
					r.done = 1'b1;
					seq_phase = PH_IDLE;
				end
			endcase
		end
		r.rlen = seq_clamp;
		r.err = seq_err;
		return r;
	endfunction

	function automatic cmd_item_t typed_item(input logic [2:0] cmd, input logic store,
		input logic [7:0] data, input logic [5:0] rlen, input logic err, input logic done);
		cmd_item_t r;
		r = '0;
		r.cmd = cmd;
		r.store = store;
		r.data = data;
		r.rlen = rlen;
		r.err = err;
		r.done = done;
		return r;
	endfunction

	function automatic void add_row(input logic nack, input logic [7:0] rx, input bit typed,
		input cmd_item_t want);
		script_row_t row;
		row.nack = nack;
		row.rx = rx;
		row.typed = typed;
		row.want = want;
		script.push_back(row);
	endfunction

	// Gap length: mostly none, often short, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 30);
	endfunction

	task automatic report_mismatch(input string name, input logic [7:0] got,
		input logic [7:0] want);
		if (got !== want) begin
			$display("result %0d: %s is %0h, expected %0h", result_count, name, got, want);
			mismatches++;
		end
	endtask

	// Presents one event and waits until the block takes it; the model then steps.
	task automatic send_event(input logic nack, input logic [7:0] rx, input bit typed,
		input cmd_item_t want);
		cmd_item_t predicted;
		@(negedge clk);
		in_valid = 1'b1;
		nack_seen = nack;
		rx_byte = rx;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predicted = predict_command(nack, rx);
		pending_commands.push_back(typed ? want : predicted);
	endtask

	// Lowers valid for a gap of the given length; zero keeps the next item back to back.
	task automatic hold_input(input int gap);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_register(input logic [2:0] index, input logic [7:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = value;
		case (index)
			REG_WRITE_ADDRESS:    wr_addr_reg = value;
			REG_READ_ADDRESS:     rd_addr_reg = value;
			REG_WRITE_LENGTH:     write_len_reg = value[2:0];
			REG_WRITE_BYTE_ZERO:  wr_bytes[0] = value;
			REG_WRITE_BYTE_ONE:   wr_bytes[1] = value;
			REG_WRITE_BYTE_TWO:   wr_bytes[2] = value;
			REG_WRITE_BYTE_THREE: wr_bytes[3] = value;
			default:              read_cap_reg = value[5:0];
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Output side: every accepted command item is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_commands.size() == 0) begin
				$display("result %0d arrived with nothing expected", result_count);
				mismatches++;
			end else begin
				oldest = pending_commands.pop_front();
				report_mismatch("bus_command", {5'b0, bus_command}, {5'b0, oldest.cmd});
				report_mismatch("tx_byte", tx_byte, oldest.tx);
				report_mismatch("rx_store", {7'b0, rx_store}, {7'b0, oldest.store});
				report_mismatch("rx_index", {3'b0, rx_index}, {3'b0, oldest.idx});
				report_mismatch("rx_data", rx_data, oldest.data);
				report_mismatch("read_length", {2'b0, read_length}, {2'b0, oldest.rlen});
				report_mismatch("error_no_ack", {7'b0, error_no_ack}, {7'b0, oldest.err});
				report_mismatch("done_res", {7'b0, done_res}, {7'b0, oldest.done});
			end
			result_count++;
		end
	end

	// Receiver back-pressure: stalls of random length at random moments, none while calm.
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			if (!stall_calm && $urandom_range(0, 99) < 25) begin
				hold = pick_gap() + 1;
				out_stall = 1'b1;
				repeat (hold - 1) @(negedge clk);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// Main stimulus. The model starts from the documented reset values, the directed
	// script runs against that default setup, and then ten phases of random events
	// follow, each under a fresh register setup written while the block is empty.
	initial begin
		int         waited;
		logic [2:0] len_pick [0:9];
		logic [5:0] cap_pick [0:9];
		logic       nack;
		logic [7:0] rx;
		int         nack_rate;

		wr_addr_reg = 8'h00;
		rd_addr_reg = 8'h01;
		write_len_reg = 3'd1;
		wr_bytes[0] = 8'h00;
		wr_bytes[1] = 8'h00;
		wr_bytes[2] = 8'h00;
		wr_bytes[3] = 8'h00;
		read_cap_reg = 6'd32;
		seq_phase = PH_IDLE;
		seq_count = 6'd0;
		seq_err = 1'b0;
		seq_clamp = 6'd32;

		// Write lengths and capacities per phase, including zero and values above the limits.
		len_pick = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4, 3'd1};
		cap_pick = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd2, 6'd33, 6'd5, 6'd40, 6'd32, 6'd3};

		// Directed script with the reset configuration: one address, one write byte.
		// First a full transaction whose length prefix is zero, so the read ends at once.
		add_row(1'b0, 8'h00, 1'b1, typed_item(CMD_START, 1'b0, 8'h00, 6'd32, 1'b0, 1'b0));
		add_row(1'b0, 8'h00, 1'b0, '0);
		add_row(1'b0, 8'h00, 1'b0, '0);
		add_row(1'b0, 8'h00, 1'b0, '0);
		add_row(1'b0, 8'h00, 1'b0, '0);
		add_row(1'b0, 8'h00, 1'b0, '0);
		add_row(1'b0, 8'h00, 1'b1, typed_item(CMD_NACK, 1'b1, 8'h00, 6'd1, 1'b0, 1'b0));
		// A not-acknowledge flag during the final stop is ignored.
		add_row(1'b1, 8'hFF, 1'b0, '0);
		add_row(1'b0, 8'hFF, 1'b0, '0);
		// Idle ignores the flag too; then the write address is refused.
		add_row(1'b1, 8'h00, 1'b0, '0);
		add_row(1'b1, 8'hFF, 1'b0, '0);
		add_row(1'b1, 8'h00, 1'b1, typed_item(CMD_STOP, 1'b0, 8'h00, 6'd32, 1'b1, 1'b0));
		add_row(1'b0, 8'h00, 1'b1, typed_item(CMD_NONE, 1'b0, 8'h00, 6'd32, 1'b1, 1'b1));
		// The next start clears the latched error; this time the write byte is refused.
		add_row(1'b0, 8'h00, 1'b1, typed_item(CMD_START, 1'b0, 8'h00, 6'd32, 1'b0, 1'b0));
		add_row(1'b0, 8'h00, 1'b0, '0);
		add_row(1'b0, 8'h00, 1'b0, '0);
		add_row(1'b1, 8'h00, 1'b0, '0);
		add_row(1'b0, 8'h00, 1'b0, '0);
		// A prefix of all ones leaves the capacity in force; the slave then refuses
		// the acknowledge that followed the first read byte.
		add_row(1'b0, 8'h00, 1'b0, '0);
		add_row(1'b0, 8'h00, 1'b0, '0);
		add_row(1'b0, 8'h00, 1'b0, '0);
		add_row(1'b0, 8'h00, 1'b0, '0);
		add_row(1'b0, 8'h00, 1'b0, '0);
		add_row(1'b0, 8'h00, 1'b0, '0);
		add_row(1'b1, 8'hFF, 1'b1, typed_item(CMD_ACK, 1'b1, 8'hFF, 6'd32, 1'b0, 1'b0));
		add_row(1'b1, 8'hAB, 1'b0, '0);
		add_row(1'b0, 8'h00, 1'b0, '0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (script[i]) begin
			send_event(script[i].nack, script[i].rx, script[i].typed, script[i].want);
			hold_input(pick_gap());
		end

		for (int p = 0; p < 10; p++) begin
			// The block must be empty before its registers change.
			@(negedge clk);
			in_valid = 1'b0;
			while (pending_commands.size() != 0) begin
				@(posedge clk);
			end
			repeat (4) @(posedge clk);

			write_register(REG_WRITE_ADDRESS, (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom));
			write_register(REG_READ_ADDRESS, (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom));
			// Upper data bits are noise the register must drop.
			write_register(REG_WRITE_LENGTH, {5'($urandom), len_pick[p]});
			write_register(REG_WRITE_BYTE_ZERO, (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom));
			write_register(REG_WRITE_BYTE_ONE, (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom));
			write_register(REG_WRITE_BYTE_TWO, (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom));
			write_register(REG_WRITE_BYTE_THREE, (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom));
			write_register(REG_READ_CAPACITY, {2'($urandom), cap_pick[p]});

			in_calm = (p % 4 == 3);
			stall_calm = (p % 5 == 2);
			// Most phases are clean transactions; two of them refuse acknowledges often.
			nack_rate = (p == 4 || p == 8) ? 40 : 4;

			for (int n = 0; n < 120; n++) begin
				nack = ($urandom_range(0, 99) < nack_rate);
				// Short prefixes keep reads brief; full-range bytes reach the clipping.
				rx = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 7)) : 8'($urandom);
				send_event(nack, rx, 1'b0, '0);
				hold_input(in_calm ? 0 : pick_gap());
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		in_calm = 1'b0;
		stall_calm = 1'b0;
		waited = 0;
		while (pending_commands.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_commands.size() != 0) begin
			$display("%0d expected results never arrived", pending_commands.size());
			mismatches++;
		end

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/i2cwr_pkg.sv
sv/i2c_write_read_length_prefixed.sv
sim/i2c_write_read_length_prefixed_tb.sv
